// ----- hdl/pfc_pkg.sv -----
`default_nettype none

package pfc_pkg;

    // letter codes and square geometry
    localparam logic [4:0] ALPHABET  = 5'd26;
    localparam logic [4:0] CELLS     = 5'd25;
    localparam logic [4:0] WALK_LAST = 5'd25;
    localparam logic [2:0] SIDE_LAST = 3'd4;
    localparam logic [4:0] LETTER_I  = 5'd8;
    localparam logic [4:0] LETTER_J  = 5'd9;

    // action codes
    localparam logic [1:0] ACT_KEY     = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_ENCRYPT = 2'd2;

    typedef logic [4:0] letter_t;

    typedef struct packed {
        logic [1:0] action;
        letter_t    key_letter;
        letter_t    first_letter;
        letter_t    second_letter;
    } pfc_in_t;

    typedef struct packed {
        letter_t cipher_first;
        letter_t cipher_second;
    } pfc_out_t;

    // row and column of a cell in the square
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } pfc_pos_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_PAIR
    } pfc_state_t;

    // controller to datapath
    typedef struct packed {
        logic place_key;
        logic walk_start;
        logic walk_step;
        logic lookup;
        logic pair;
    } pfc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ready;
        logic walk_last;
    } pfc_status_t;

endpackage

`default_nettype wire

// ----- hdl/pfc_ctrl.sv -----
`default_nettype none

module pfc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          action,
    input  wire pfc_pkg::pfc_status_t status,
    output pfc_pkg::pfc_cmd_t        cmd,
    output logic                     busy,
    output logic                     done
);
    import pfc_pkg::*;

    pfc_state_t state_reg;
    pfc_state_t state_next;
    logic       done_reg;
    logic       done_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    // state register and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_FINISH) && !status.ready)
                    state_next = ST_FILL;
                else if (accept && (action == ACT_ENCRYPT) && status.ready)
                    state_next = ST_PAIR;
            end
            ST_FILL:
            begin
                if (status.walk_last)
                    state_next = ST_IDLE;
            end
            ST_PAIR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        busy      = 1'b1;
        done_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.place_key  = accept && (action == ACT_KEY) && !status.ready;
                cmd.walk_start = accept && (action == ACT_FINISH) && !status.ready;
                cmd.lookup     = accept && (action == ACT_ENCRYPT) && status.ready;
            end
            ST_FILL:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_PAIR:
            begin
                cmd.pair  = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hdl/pfc_datapath.sv -----
`default_nettype none

module pfc_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pfc_pkg::pfc_in_t     item,
    input  wire pfc_pkg::pfc_cmd_t    cmd,
    output pfc_pkg::pfc_status_t      status,
    output pfc_pkg::pfc_out_t         result
);
    import pfc_pkg::*;

    // key square in row-major order and letter-to-cell map (i and j share i's entry)
    letter_t  key_sq_mem [CELLS];
    pfc_pos_t cell_mem   [ALPHABET];

    logic [25:0] used_reg;
    logic [25:0] used_next;
    logic [4:0]  fill_reg;
    logic [4:0]  fill_next;
    pfc_pos_t    fpos_reg;
    pfc_pos_t    fpos_next;
    logic        ready_reg;
    logic        ready_next;
    logic [4:0]  walk_reg;
    logic [4:0]  walk_next;

    pfc_pos_t    cell1_reg;
    pfc_pos_t    cell2_reg;
    logic        zero1_reg;
    logic        zero2_reg;
    letter_t     ks1_reg;
    letter_t     ks2_reg;

    logic        place;
    letter_t     place_letter;
    logic [4:0]  place_addr;
    logic [4:0]  rd_addr1;
    logic [4:0]  rd_addr2;
    pfc_pos_t    pos1;
    pfc_pos_t    pos2;
    pfc_pos_t    out1;
    pfc_pos_t    out2;
    logic [4:0]  sq_addr1;
    logic [4:0]  sq_addr2;

    function automatic logic [4:0] map_addr(letter_t l);
        logic [4:0] a;
        if (l >= ALPHABET)
            a = 5'd0;
        else if (l == LETTER_J)
            a = LETTER_I;
        else
            a = l;
        return a;
    endfunction

    function automatic logic [2:0] inc5(logic [2:0] x);
        return (x >= SIDE_LAST) ? 3'd0 : 3'(x + 3'd1);
    endfunction

    function automatic logic [4:0] cell_index(pfc_pos_t p);
        return 5'({2'b00, p.row} * 5'd5) + {2'b00, p.col};
    endfunction

    // choose the letter to place, from a key item or the finish walk
    always_comb
    begin
        place_letter = cmd.walk_step ? walk_reg : item.key_letter;
        place = 1'b0;
        if (cmd.place_key)
            place = (item.key_letter < ALPHABET) && !used_reg[item.key_letter]
                    && (fill_reg < CELLS);
        else if (cmd.walk_step)
            place = !used_reg[walk_reg] && (fill_reg < CELLS);
        place_addr = map_addr(place_letter);
    end

    // square build bookkeeping
    always_comb
    begin
        used_next  = used_reg;
        fill_next  = fill_reg;
        fpos_next  = fpos_reg;
        ready_next = ready_reg;
        walk_next  = walk_reg;
        if (place)
        begin
            used_next[place_letter] = 1'b1;
            if ((place_letter == LETTER_I) || (place_letter == LETTER_J))
            begin
                used_next[LETTER_I] = 1'b1;
                used_next[LETTER_J] = 1'b1;
            end
            fill_next = 5'(fill_reg + 5'd1);
            if (fpos_reg.col >= SIDE_LAST)
            begin
                fpos_next.col = 3'd0;
                fpos_next.row = 3'(fpos_reg.row + 3'd1);
            end
            else
            begin
                fpos_next.col = 3'(fpos_reg.col + 3'd1);
            end
        end
        if (cmd.walk_start)
            walk_next = 5'd0;
        else if (cmd.walk_step)
            walk_next = 5'(walk_reg + 5'd1);
        if (cmd.walk_step && (walk_reg == WALK_LAST))
            ready_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            fill_reg  <= '0;
            fpos_reg  <= '0;
            ready_reg <= 1'b0;
            walk_reg  <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            fpos_reg  <= fpos_next;
            ready_reg <= ready_next;
            walk_reg  <= walk_next;
        end
    end

    // letter-to-cell map, one write and two registered reads
    assign rd_addr1 = map_addr(item.first_letter);
    assign rd_addr2 = map_addr(item.second_letter);

    always_ff @(posedge clk)
    begin
        if (place)
            cell_mem[place_addr] <= fpos_reg;
        if (cmd.lookup)
        begin
            cell1_reg <= cell_mem[rd_addr1];
            cell2_reg <= cell_mem[rd_addr2];
            zero1_reg <= (item.first_letter >= ALPHABET);
            zero2_reg <= (item.second_letter >= ALPHABET);
        end
    end

    // playfair rules on the two positions
    always_comb
    begin
        pos1 = zero1_reg ? '0 : cell1_reg;
        pos2 = zero2_reg ? '0 : cell2_reg;
        if (pos1.row == pos2.row)
        begin
            out1 = '{row: pos1.row, col: inc5(pos1.col)};
            out2 = '{row: pos2.row, col: inc5(pos2.col)};
        end
        else if (pos1.col == pos2.col)
        begin
            out1 = '{row: inc5(pos1.row), col: pos1.col};
            out2 = '{row: inc5(pos2.row), col: pos2.col};
        end
        else
        begin
            out1 = '{row: pos1.row, col: pos2.col};
            out2 = '{row: pos2.row, col: pos1.col};
        end
        sq_addr1 = cell_index(out1);
        sq_addr2 = cell_index(out2);
    end

    // key square, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (place)
            key_sq_mem[fill_reg] <= place_letter;
        if (cmd.pair)
        begin
            ks1_reg <= key_sq_mem[sq_addr1];
            ks2_reg <= key_sq_mem[sq_addr2];
        end
    end

    assign status.ready         = ready_reg;
    assign status.walk_last     = (walk_reg == WALK_LAST);
    assign result.cipher_first  = ks1_reg;
    assign result.cipher_second = ks2_reg;

endmodule

`default_nettype wire

// ----- hdl/playfair_digraph_cipher.sv -----
// channel   signals              transfer when
// ------    -------------------  ------------------------------
// item      start, busy, item    start high and busy low
// result    done, result         done high (one cycle, no stall)
//
// key letter item: handled in the transfer cycle, busy stays low.
// finish item: a 26-letter walk, one letter per cycle.
// encrypt item: the result strobes after two registered memory reads in a row (cell
//   map, then key square); busy is high in between, and the next item can be taken
//   in the same cycle that the result shows.
// reset is asynchronous, active low, and clears the square state; no clearing pass.
// results cannot be held off; the result shows for exactly one cycle.
`default_nettype none

module playfair_digraph_cipher (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pfc_pkg::pfc_in_t item,
    output logic                  done,
    output pfc_pkg::pfc_out_t     result
);
    import pfc_pkg::*;

    pfc_cmd_t    cmd;
    pfc_status_t status;

    pfc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    pfc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire

// ----- hdl/pfc_checker.sv -----
`default_nettype none

module pfc_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire pfc_pkg::pfc_in_t item,
    input wire logic             done,
    input wire pfc_pkg::pfc_out_t result
);
    import pfc_pkg::*;

    // a result follows a busy cycle spent on the pair
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // results never come back to back
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // busy only starts from an item transfer
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item transfer");

    // a key letter transfer leaves busy low
    a_key_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.action == ACT_KEY)) |=> !busy)
        else $error("busy after a key letter transfer");

    // cipher letters are valid letter codes when a result shows
    a_letters_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.cipher_first < ALPHABET) && (result.cipher_second < ALPHABET)))
        else $error("cipher letter out of range");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ----- tb/playfair_digraph_cipher_tb.sv -----
`timescale 1ns / 100ps

module playfair_digraph_cipher_tb;

    import pfc_pkg::*;

    // action code the block does not define
    localparam logic [1:0] ACT_UNDEF = 2'd3;
    localparam letter_t LETTER_ABSENT = ALPHABET;
    localparam int SQ_SIDE = 5;
    localparam int RANDOM_ENCRYPTS = 490;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        pfc_in_t  it;
        logic     pinned;
        pfc_out_t cipher;
    } plan_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    pfc_in_t  item;
    logic     done;
    pfc_out_t result;

    // hand-typed ciphertext travels with the item it belongs to
    logic     cipher_pinned;
    pfc_out_t pinned_cipher;

    // local copy of the key square and its lookup state
    letter_t     square_cells [CELLS];
    logic [4:0]  cell_of_letter [ALPHABET];
    logic [25:0] letters_placed;
    logic [4:0]  cells_filled;
    logic        square_done;

    pfc_out_t  cipher_due [$];
    plan_row_t directed_rows [$];
    int        fail_count;
    int        encrypts_sent;
    int        cycle_count;
    int        burst_left;

    playfair_digraph_cipher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL playfair_digraph_cipher");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // append a letter to the square, i and j share one cell
    function automatic void add_letter(input letter_t l);
        if (l >= ALPHABET || cells_filled >= CELLS)
            return;
        square_cells[cells_filled] = l;
        cell_of_letter[l] = cells_filled;
        letters_placed[l] = 1'b1;
        if (l == LETTER_I || l == LETTER_J)
        begin
            cell_of_letter[LETTER_I] = cells_filled;
            cell_of_letter[LETTER_J] = cells_filled;
            letters_placed[LETTER_I] = 1'b1;
            letters_placed[LETTER_J] = 1'b1;
        end
        cells_filled++;
    endfunction

    // update the square for one item; returns 1 when a ciphertext pair comes out
    function automatic logic apply_to_square(input pfc_in_t it, output pfc_out_t ct);
        int c1, c2, r1, r2, k1, k2, o1, o2;
        ct = '0;
        case (it.action)
            ACT_KEY:
                if (!square_done && it.key_letter < ALPHABET && !letters_placed[it.key_letter])
                    add_letter(it.key_letter);
            ACT_FINISH:
                if (!square_done)
                begin
                    for (int l = 0; l < ALPHABET; l++)
                        if (!letters_placed[l])
                            add_letter(letter_t'(l));
                    square_done = 1'b1;
                end
            ACT_ENCRYPT:
                if (square_done)
                begin
                    // absent or out-of-range letters sit at row 0, column 0
                    c1 = (it.first_letter < ALPHABET) ? int'(cell_of_letter[it.first_letter]) : 0;
                    c2 = (it.second_letter < ALPHABET) ? int'(cell_of_letter[it.second_letter]) : 0;
                    r1 = c1 / SQ_SIDE;
                    k1 = c1 % SQ_SIDE;
                    r2 = c2 / SQ_SIDE;
                    k2 = c2 % SQ_SIDE;
                    if (r1 == r2)
                    begin
                        o1 = r1 * SQ_SIDE + (k1 + 1) % SQ_SIDE;
                        o2 = r2 * SQ_SIDE + (k2 + 1) % SQ_SIDE;
                    end
                    else if (k1 == k2)
                    begin
                        o1 = ((r1 + 1) % SQ_SIDE) * SQ_SIDE + k1;
                        o2 = ((r2 + 1) % SQ_SIDE) * SQ_SIDE + k2;
                    end
                    else
                    begin
                        o1 = r1 * SQ_SIDE + k2;
                        o2 = r2 * SQ_SIDE + k1;
                    end
                    ct.cipher_first = square_cells[o1];
                    ct.cipher_second = square_cells[o2];
                    return 1'b1;
                end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // check results, then record accepted items
    always @(posedge clk)
    begin
        pfc_out_t predicted;
        pfc_out_t oldest;
        logic     has_cipher;
        if (done === 1'b1)
        begin
            if (cipher_due.size() == 0)
                note_failure($sformatf("cycle %0d: unexpected result first %0d second %0d",
                    cycle_count, result.cipher_first, result.cipher_second));
            else
            begin
                oldest = cipher_due.pop_front();
                if (result.cipher_first !== oldest.cipher_first ||
                    result.cipher_second !== oldest.cipher_second)
                    note_failure($sformatf(
                        "cycle %0d: expected first %0d second %0d, got first %0d second %0d",
                        cycle_count, oldest.cipher_first, oldest.cipher_second,
                        result.cipher_first, result.cipher_second));
            end
        end
        if (start && !busy)
        begin
            has_cipher = apply_to_square(item, predicted);
            if (has_cipher)
            begin
                if (cipher_pinned)
                    predicted = pinned_cipher;
                cipher_due = {cipher_due, predicted};
            end
        end
    end

    task automatic add_row(input logic [1:0] act, input int key, input int first,
                           input int second, input logic pin, input int cf, input int cs);
        plan_row_t row;
        row.it.action = act;
        row.it.key_letter = letter_t'(key);
        row.it.first_letter = letter_t'(first);
        row.it.second_letter = letter_t'(second);
        row.pinned = pin;
        row.cipher.cipher_first = letter_t'(cf);
        row.cipher.cipher_second = letter_t'(cs);
        directed_rows = {directed_rows, row};
    endtask

    // one transfer, followed by an idle gap at the end of some bursts
    task automatic send_item(input pfc_in_t it, input logic pin, input pfc_out_t pin_val);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        cipher_pinned <= pin;
        pinned_cipher <= pin_val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk) start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        pfc_in_t it;
        int      pick;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cipher_pinned = 1'b0;
        pinned_cipher = '0;
        fail_count = 0;
        encrypts_sent = 0;
        cycle_count = 0;
        burst_left = $urandom_range(1, 10);
        letters_placed = '0;
        cells_filled = '0;
        square_done = 1'b0;
        foreach (square_cells[i])
            square_cells[i] = '0;
        foreach (cell_of_letter[i])
            cell_of_letter[i] = '0;

        // key "jumped" with repeats, twin and out-of-range letters mixed in;
        // finished square rows: j u m p e / d a b c f / g h k l n / o q r s t / v w x y z
        add_row(ACT_ENCRYPT, 0, 0, 0, 1'b0, 0, 0);      // encrypt before finish
        add_row(ACT_UNDEF, 31, 31, 31, 1'b0, 0, 0);
        add_row(ACT_KEY, LETTER_J, 0, 0, 1'b0, 0, 0);
        add_row(ACT_KEY, 20, 0, 0, 1'b0, 0, 0);         // u
        add_row(ACT_KEY, 31, 0, 0, 1'b0, 0, 0);         // out of range
        add_row(ACT_KEY, 12, 0, 0, 1'b0, 0, 0);         // m
        add_row(ACT_KEY, 15, 0, 0, 1'b0, 0, 0);         // p
        add_row(ACT_KEY, LETTER_J, 0, 0, 1'b0, 0, 0);   // repeat
        add_row(ACT_KEY, LETTER_I, 0, 0, 1'b0, 0, 0);   // twin of j
        add_row(ACT_KEY, LETTER_ABSENT, 0, 0, 1'b0, 0, 0);
        add_row(ACT_KEY, 4, 0, 0, 1'b0, 0, 0);          // e
        add_row(ACT_KEY, 3, 0, 0, 1'b0, 0, 0);          // d
        add_row(ACT_FINISH, 0, 0, 0, 1'b0, 0, 0);
        add_row(ACT_KEY, 0, 0, 0, 1'b0, 0, 0);          // key letter after finish
        add_row(ACT_FINISH, 0, 0, 0, 1'b0, 0, 0);       // finish when ready
        add_row(ACT_ENCRYPT, 0, 0, 25, 1'b1, 5, 22);    // a z: rectangle -> f w
        add_row(ACT_ENCRYPT, 0, 31, LETTER_ABSENT, 1'b1, 20, 20);
        add_row(ACT_ENCRYPT, 0, LETTER_I, LETTER_J, 1'b1, 20, 20);
        add_row(ACT_ENCRYPT, 0, 0, LETTER_ABSENT, 1'b1, 3, 20);
        add_row(ACT_ENCRYPT, 0, 4, LETTER_J, 1'b1, 9, 20);  // row wrap
        add_row(ACT_ENCRYPT, 0, 25, 4, 1'b1, 4, 5);         // column wrap
        add_row(ACT_ENCRYPT, 0, 25, 25, 1'b1, 21, 21);      // doubled letter
        add_row(ACT_UNDEF, 0, 0, 0, 1'b0, 0, 0);
        add_row(ACT_ENCRYPT, 31, LETTER_ABSENT, 31, 1'b0, 0, 0);
        add_row(ACT_ENCRYPT, 0, 7, 18, 1'b0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].pinned, directed_rows[i].cipher);

        // mostly encrypts over the whole square, some ignored items as noise
        while (encrypts_sent < RANDOM_ENCRYPTS)
        begin
            pick = $urandom_range(0, 99);
            it.key_letter = letter_t'($urandom_range(0, 31));
            it.first_letter = letter_t'($urandom_range(0, 31));
            it.second_letter = letter_t'($urandom_range(0, 31));
            if (pick < 85)
            begin
                it.action = ACT_ENCRYPT;
                if ($urandom_range(0, 7) != 0)
                    it.first_letter = letter_t'($urandom_range(0, 25));
                if ($urandom_range(0, 7) != 0)
                    it.second_letter = letter_t'($urandom_range(0, 25));
                if ($urandom_range(0, 9) == 0)
                    it.second_letter = it.first_letter;
                encrypts_sent++;
            end
            else if (pick < 90)
                it.action = ACT_KEY;
            else if (pick < 95)
                it.action = ACT_FINISH;
            else
                it.action = ACT_UNDEF;
            send_item(it, 1'b0, '0);
        end

        // drain and settle
        @(negedge clk) start <= 1'b0;
        while (cipher_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS playfair_digraph_cipher");
        else
            $display("FAIL playfair_digraph_cipher");
        $finish;
    end

endmodule
